// ----- src/clex_pkg.sv -----
// Types and constants for the C subset lexer: lexer states, token codes,
// character codes, keyword spellings and the result record.
// No dependencies.
package clex_pkg;

	typedef enum logic [4:0] {
		S_IDLE, S_IDENT, S_INT, S_DOT, S_FRAC, S_EXP, S_ESIGN, S_EDIG,
		S_CHAR0, S_CHAR1, S_STR, S_AMP, S_BAR, S_BANG, S_EQ, S_LT, S_GT,
		S_SLASH, S_COMMENT
	} lex_state_t;

	// token codes
	localparam logic [5:0] TK_ID        = 6'd0;
	localparam logic [5:0] TK_CT_INT    = 6'd12;
	localparam logic [5:0] TK_CT_REAL   = 6'd13;
	localparam logic [5:0] TK_CT_CHAR   = 6'd14;
	localparam logic [5:0] TK_CT_STRING = 6'd15;
	localparam logic [5:0] TK_COMMA     = 6'd16;
	localparam logic [5:0] TK_SEMI      = 6'd17;
	localparam logic [5:0] TK_LPAREN    = 6'd18;
	localparam logic [5:0] TK_RPAREN    = 6'd19;
	localparam logic [5:0] TK_LBRACK    = 6'd20;
	localparam logic [5:0] TK_RBRACK    = 6'd21;
	localparam logic [5:0] TK_LBRACE    = 6'd22;
	localparam logic [5:0] TK_RBRACE    = 6'd23;
	localparam logic [5:0] TK_END       = 6'd24;
	localparam logic [5:0] TK_ADD       = 6'd25;
	localparam logic [5:0] TK_SUB       = 6'd26;
	localparam logic [5:0] TK_MUL       = 6'd27;
	localparam logic [5:0] TK_DIV       = 6'd28;
	localparam logic [5:0] TK_DOT       = 6'd29;
	localparam logic [5:0] TK_AND       = 6'd30;
	localparam logic [5:0] TK_OR        = 6'd31;
	localparam logic [5:0] TK_NOT       = 6'd32;
	localparam logic [5:0] TK_ASSIGN    = 6'd33;
	localparam logic [5:0] TK_EQUAL     = 6'd34;
	localparam logic [5:0] TK_NOTEQ     = 6'd35;
	localparam logic [5:0] TK_LESS      = 6'd36;
	localparam logic [5:0] TK_LESSEQ    = 6'd37;
	localparam logic [5:0] TK_GREATER   = 6'd38;
	localparam logic [5:0] TK_GREATEREQ = 6'd39;
	localparam logic [5:0] TK_ERROR     = 6'd40;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam int          NUM_KW    = 11;
	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

	// keyword spellings, first character in the lowest byte, zero padded
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h006b61657262,   // break
		48'h000072616863,   // char
		48'h656c62756f64,   // double
		48'h000065736c65,   // else
		48'h000000726f66,   // for
		48'h000000006669,   // if
		48'h000000746e69,   // int
		48'h6e7275746572,   // return
		48'h746375727473,   // struct
		48'h000064696f76,   // void
		48'h00656c696877    // while
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd5, 3'd4, 3'd6, 3'd4, 3'd3, 3'd2, 3'd3, 3'd6, 3'd6, 3'd4, 3'd5
	};

	typedef struct packed {
		logic [5:0]  code;
		logic [15:0] start;
		logic [15:0] len;
		logic [30:0] value;
	} tok_t;

	typedef struct packed {
		tok_t        tok;
		logic [15:0] line;
		logic        last;
	} result_t;

endpackage

// ----- src/c_subset_lexer.sv -----
// A byte accepted into the input register is lexed from there and its results are written to the
// result queue. Throughput: one byte per cycle while the queue has room; a byte that closes one
// token and is itself a token gives two results, which leave one a cycle while m_tready is high.
// A four-entry result queue stalls the input register when fewer than two entries are free.
// Asynchronous active-low reset: lexer idle, line 1, position 0, queue empty; no clearing pass.
// Depends on clex_pkg.
module c_subset_lexer #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] src_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] token_code, [21:6] line_number, [37:22] start_position,
	// [53:38] token_length, [84:54] token_value, [87:85] zero
	output logic [87:0] m_tdata,
	output logic        m_tlast     // last_of_run
);
	import clex_pkg::*;

	localparam int WIN_BITS = 8 * KEYWORD_CHARS;
	localparam int QDEPTH   = 4;
	localparam int QPTR     = $clog2(QDEPTH);

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       proc;          // the registered byte is lexed this cycle
	logic [QPTR:0] count_q;

	// room for two results regardless of a pop this cycle
	assign proc     = valid_s1 && (count_q <= (QPTR+1)'(QDEPTH - 2));
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// ---------------- lexer state ----------------
	lex_state_t                 state_q, state_d;
	logic [15:0]                line_q, line_d;
	logic [POSITION_BITS-1:0]   pos_q;
	logic [POSITION_BITS-1:0]   tstart_q, tstart_d;
	logic [15:0]                len_q, len_d;
	logic [30:0]                acc_q, acc_d;
	logic [WIN_BITS-1:0]        win_q, win_d;
	logic [7:0]                 chr_q, chr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			line_q   <= 16'd1;
			pos_q    <= '0;
			tstart_q <= '0;
			len_q    <= '0;
			acc_q    <= '0;
			win_q    <= '0;
			chr_q    <= '0;
		end else if (proc) begin
			state_q  <= state_d;
			line_q   <= line_d;
			pos_q    <= pos_q + 1'b1;
			tstart_q <= tstart_d;
			len_q    <= len_d;
			acc_q    <= acc_d;
			win_q    <= win_d;
			chr_q    <= chr_d;
		end
	end

	// ---------------- next state and tokens ----------------
	logic [7:0]  b;
	logic        is_dig, is_let, is_e;
	logic [15:0] grown;
	logic [15:0] tstart16, pos16, pos1_16;
	logic [31:0] tstart_w, pos_w, pos1_w;
	logic [POSITION_BITS-1:0] pos_plus1;
	logic [34:0] acc_mul;
	logic [30:0] acc_next;
	logic [5:0]  id_code;
	logic        consumed;
	logic        adv_v, idl_v;
	tok_t        adv_tok, idl_tok;

	function automatic tok_t mk_tok(logic [5:0] c, logic [15:0] s, logic [15:0] l,
			logic [30:0] v);
		tok_t t;
		t.code  = c;
		t.start = s;
		t.len   = l;
		t.value = v;
		return t;
	endfunction

	assign b         = byte_s1;
	assign is_dig    = (b >= CH_ZERO) && (b <= CH_NINE);
	assign is_let    = ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ||
	                   ((b >= CH_UP_A) && (b <= CH_UP_Z)) || (b == CH_USCORE);
	assign is_e      = (b == CH_LOW_E) || (b == CH_UP_E);
	assign grown     = (len_q != 16'hFFFF) ? len_q + 16'd1 : len_q;
	assign pos_plus1 = pos_q + 1'b1;
	// positions are reported modulo 2^16
	assign tstart_w  = 32'(tstart_q);
	assign pos_w     = 32'(pos_q);
	assign pos1_w    = 32'(pos_plus1);
	assign tstart16  = tstart_w[15:0];
	assign pos16     = pos_w[15:0];
	assign pos1_16   = pos1_w[15:0];

	// decimal accumulate: acc*10 + digit, saturating
	assign acc_mul  = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(b[3:0]);
	assign acc_next = (acc_mul > 35'(VALUE_MAX)) ? VALUE_MAX : acc_mul[30:0];

	// keyword match on the collected window
	always_comb begin
		id_code = TK_ID;
		for (int k = 0; k < NUM_KW; k++) begin
			if ((len_q == 16'(KW_LEN[k])) && (win_q == WIN_BITS'(KW_TEXT[k]))) begin
				id_code = 6'(k + 1);
			end
		end
	end

	always_comb begin
		state_d  = S_IDLE;
		line_d   = line_q;
		tstart_d = tstart_q;
		len_d    = len_q;
		acc_d    = acc_q;
		win_d    = win_q;
		chr_d    = chr_q;
		adv_v    = 1'b0;
		idl_v    = 1'b0;
		adv_tok  = mk_tok(TK_ERROR, tstart16, len_q, '0);
		idl_tok  = mk_tok(TK_ERROR, pos16, 16'd1, '0);
		consumed = 1'b0;

		// continue the token in progress
		unique case (state_q)
			S_IDENT: begin
				if (is_let || is_dig) begin
					for (int i = 0; i < KEYWORD_CHARS; i++) begin
						if (len_q == 16'(i)) begin
							win_d[8*i +: 8] = b;
						end
					end
					len_d    = grown;
					state_d  = S_IDENT;
					consumed = 1'b1;
				end else begin
					adv_v   = 1'b1;
					adv_tok = mk_tok(id_code, tstart16, len_q, '0);
				end
			end
			S_INT: begin
				if (is_dig) begin
					acc_d    = acc_next;
					len_d    = grown;
					state_d  = S_INT;
					consumed = 1'b1;
				end else if (b == CH_DOT) begin
					len_d    = grown;
					state_d  = S_DOT;
					consumed = 1'b1;
				end else if (is_e) begin
					len_d    = grown;
					state_d  = S_EXP;
					consumed = 1'b1;
				end else begin
					adv_v   = 1'b1;
					adv_tok = mk_tok(TK_CT_INT, tstart16, len_q, acc_q);
				end
			end
			S_DOT: begin
				if (is_dig) begin
					len_d    = grown;
					state_d  = S_FRAC;
					consumed = 1'b1;
				end else begin
					adv_v = 1'b1;
				end
			end
			S_FRAC: begin
				if (is_dig) begin
					len_d    = grown;
					state_d  = S_FRAC;
					consumed = 1'b1;
				end else if (is_e) begin
					len_d    = grown;
					state_d  = S_EXP;
					consumed = 1'b1;
				end else begin
					adv_v   = 1'b1;
					adv_tok = mk_tok(TK_CT_REAL, tstart16, len_q, '0);
				end
			end
			S_EXP: begin
				if ((b == CH_PLUS) || (b == CH_MINUS)) begin
					len_d    = grown;
					state_d  = S_ESIGN;
					consumed = 1'b1;
				end else if (is_dig) begin
					len_d    = grown;
					state_d  = S_EDIG;
					consumed = 1'b1;
				end else begin
					adv_v = 1'b1;
				end
			end
			S_ESIGN: begin
				if (is_dig) begin
					len_d    = grown;
					state_d  = S_EDIG;
					consumed = 1'b1;
				end else begin
					adv_v = 1'b1;
				end
			end
			S_EDIG: begin
				if (is_dig) begin
					len_d    = grown;
					state_d  = S_EDIG;
					consumed = 1'b1;
				end else begin
					adv_v   = 1'b1;
					adv_tok = mk_tok(TK_CT_REAL, tstart16, len_q, '0);
				end
			end
			S_CHAR0: begin
				if (b == CH_SQUOTE) begin
					// empty char constant: closing quote swallowed
					adv_v    = 1'b1;
					adv_tok  = mk_tok(TK_ERROR, tstart16, 16'd0, '0);
					consumed = 1'b1;
				end else if (b == CH_NUL) begin
					adv_v = 1'b1;
				end else begin
					chr_d    = b;
					len_d    = 16'd1;
					state_d  = S_CHAR1;
					consumed = 1'b1;
				end
			end
			S_CHAR1: begin
				adv_v = 1'b1;
				if (b == CH_SQUOTE) begin
					adv_tok  = mk_tok(TK_CT_CHAR, tstart16, 16'd1, 31'(chr_q));
					consumed = 1'b1;
				end
			end
			S_STR: begin
				if (b == CH_DQUOTE) begin
					adv_v    = 1'b1;
					adv_tok  = mk_tok(TK_CT_STRING, tstart16, len_q, '0);
					consumed = 1'b1;
				end else if (b == CH_NUL) begin
					adv_v = 1'b1;
				end else begin
					len_d    = grown;
					state_d  = S_STR;
					consumed = 1'b1;
				end
			end
			S_AMP: begin
				adv_v = 1'b1;
				if (b == CH_AMP) begin
					adv_tok  = mk_tok(TK_AND, tstart16, 16'd2, '0);
					consumed = 1'b1;
				end
			end
			S_BAR: begin
				adv_v = 1'b1;
				if (b == CH_BAR) begin
					adv_tok  = mk_tok(TK_OR, tstart16, 16'd2, '0);
					consumed = 1'b1;
				end
			end
			S_BANG, S_EQ, S_LT, S_GT: begin
				adv_v    = 1'b1;
				consumed = (b == CH_EQ);
				unique case (state_q)
					S_BANG:  adv_tok = mk_tok(consumed ? TK_NOTEQ : TK_NOT,
					                          tstart16, consumed ? 16'd2 : 16'd1, '0);
					S_EQ:    adv_tok = mk_tok(consumed ? TK_EQUAL : TK_ASSIGN,
					                          tstart16, consumed ? 16'd2 : 16'd1, '0);
					S_LT:    adv_tok = mk_tok(consumed ? TK_LESSEQ : TK_LESS,
					                          tstart16, consumed ? 16'd2 : 16'd1, '0);
					default: adv_tok = mk_tok(consumed ? TK_GREATEREQ : TK_GREATER,
					                          tstart16, consumed ? 16'd2 : 16'd1, '0);
				endcase
			end
			S_SLASH: begin
				if (b == CH_SLASH) begin
					state_d  = S_COMMENT;
					consumed = 1'b1;
				end else begin
					adv_v   = 1'b1;
					adv_tok = mk_tok(TK_DIV, tstart16, 16'd1, '0);
				end
			end
			S_COMMENT: begin
				if ((b != CH_LF) && (b != CH_CR) && (b != CH_NUL)) begin
					state_d  = S_COMMENT;
					consumed = 1'b1;
				end
			end
			default: begin
				consumed = 1'b0;   // idle and unused codes
			end
		endcase

		// take the byte up from idle
		if (!consumed) begin
			state_d = S_IDLE;
			if (is_let) begin
				state_d  = S_IDENT;
				tstart_d = pos_q;
				len_d    = 16'd1;
				win_d    = WIN_BITS'(b);
			end else if (is_dig) begin
				state_d  = S_INT;
				tstart_d = pos_q;
				len_d    = 16'd1;
				acc_d    = 31'(b[3:0]);
			end else if ((b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
				// text starts after the opening quote
				state_d  = (b == CH_DQUOTE) ? S_STR : S_CHAR0;
				tstart_d = pos_plus1;
				len_d    = 16'd0;
			end else begin
				unique case (b)
					CH_COMMA:  begin idl_v = 1'b1; idl_tok.code = TK_COMMA;  end
					CH_SEMI:   begin idl_v = 1'b1; idl_tok.code = TK_SEMI;   end
					CH_LPAREN: begin idl_v = 1'b1; idl_tok.code = TK_LPAREN; end
					CH_RPAREN: begin idl_v = 1'b1; idl_tok.code = TK_RPAREN; end
					CH_LBRACK: begin idl_v = 1'b1; idl_tok.code = TK_LBRACK; end
					CH_RBRACK: begin idl_v = 1'b1; idl_tok.code = TK_RBRACK; end
					CH_LBRACE: begin idl_v = 1'b1; idl_tok.code = TK_LBRACE; end
					CH_RBRACE: begin idl_v = 1'b1; idl_tok.code = TK_RBRACE; end
					CH_NUL: begin
						idl_v       = 1'b1;
						idl_tok.code = TK_END;
						idl_tok.len  = 16'd0;
					end
					CH_PLUS:   begin idl_v = 1'b1; idl_tok.code = TK_ADD;    end
					CH_MINUS:  begin idl_v = 1'b1; idl_tok.code = TK_SUB;    end
					CH_STAR:   begin idl_v = 1'b1; idl_tok.code = TK_MUL;    end
					CH_DOT:    begin idl_v = 1'b1; idl_tok.code = TK_DOT;    end
					CH_AMP, CH_BAR, CH_BANG, CH_EQ, CH_LT, CH_GT, CH_SLASH: begin
						unique case (b)
							CH_AMP:  state_d = S_AMP;
							CH_BAR:  state_d = S_BAR;
							CH_BANG: state_d = S_BANG;
							CH_EQ:   state_d = S_EQ;
							CH_LT:   state_d = S_LT;
							CH_GT:   state_d = S_GT;
							default: state_d = S_SLASH;
						endcase
						tstart_d = pos_q;
						len_d    = 16'd1;
					end
					CH_SPACE, CH_TAB, CH_CR: begin
						idl_v = 1'b0;
					end
					CH_LF: begin
						if (line_q != 16'hFFFF) begin
							line_d = line_q + 16'd1;
						end
					end
					default: begin
						idl_v = 1'b1;   // byte starts no token
					end
				endcase
			end
		end
	end

	// ---------------- result queue ----------------
	result_t       q_mem [QDEPTH];
	logic [QPTR-1:0] wr_q, rd_q;
	result_t       ent0, ent1;
	logic [1:0]    n_res;
	logic          pop;

	assign n_res = {1'b0, adv_v} + {1'b0, idl_v};
	assign pop   = m_tvalid && m_tready;

	always_comb begin
		ent0.tok  = adv_v ? adv_tok : idl_tok;
		ent0.line = line_q;
		ent0.last = !(adv_v && idl_v);
		ent1.tok  = idl_tok;
		ent1.line = line_q;
		ent1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (proc) begin
				wr_q <= wr_q + QPTR'(n_res);
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (QPTR+1)'(proc ? n_res : 2'd0) - (QPTR+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (proc && (n_res != 2'd0)) begin
			q_mem[wr_q] <= ent0;
		end
		if (proc && (n_res == 2'd2)) begin
			q_mem[wr_q + 1'b1] <= ent1;
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {3'b000, q_mem[rd_q].tok.value, q_mem[rd_q].tok.len,
	                   q_mem[rd_q].tok.start, q_mem[rd_q].line, q_mem[rd_q].tok.code};
	assign m_tlast  = q_mem[rd_q].last;

	// ---------------- checks ----------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR+1)'(QDEPTH))
		else $error("result queue overfilled");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (byte_s1 == CH_NUL) |=> state_q == S_IDLE)
		else $error("lexer not idle after end of input");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (byte_s1 == CH_NUL) |-> idl_v && (idl_tok.code == TK_END))
		else $error("end of input gave no END token");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 16'd0)
		else $error("line count reached zero");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the C subset lexer: directed and random source bytes on the
// input stream, tokens predicted in the bench and compared field by field on the output.
// Depends on clex_pkg and c_subset_lexer.
module tb_top;
	import clex_pkg::*;

	localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
	localparam int SOURCE_ITEMS = 1450;
	localparam int TAIL_ROOM    = 200;    // rough size of the closing burst of tokens

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [7:0] b;
		idle_mode_t mode;
	} source_item_t;

	typedef struct packed {
		logic [5:0]  code;
		logic [15:0] line;
		logic [15:0] start;
		logic [15:0] len;
		logic [30:0] value;
		logic        last;
	} token_rec_t;

	// lone &, lone |, bad exponent, empty and unclosed char constants, newline in a
	// string, zero inside a char and a string, bad number after END, bytes 0xFF and 0x01
	localparam logic [7:0] OPENING [27] = '{
		8'hFF, 8'h01, CH_AMP, "x", CH_BAR, CH_SPACE, "1", CH_LOW_E, CH_PLUS, CH_SEMI,
		CH_SQUOTE, CH_SQUOTE, CH_SQUOTE, "a", "b", CH_DQUOTE, "q", CH_LF, CH_DQUOTE,
		CH_SQUOTE, CH_NUL, CH_DQUOTE, "z", CH_NUL, "1", CH_DOT, CH_SEMI
	};
	localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	string keyword_list [11] = '{
		"break", "char", "double", "else", "for", "if",
		"int", "return", "struct", "void", "while"
	};
	string punct_list [23] = '{
		",", ";", "(", ")", "[", "]", "{", "}", "+", "-", "*", "/", ".",
		"&&", "||", "!", "=", "==", "!=", "<", "<=", ">", ">="
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic        m_tlast;

	source_item_t source_bytes [$];
	token_rec_t   expected_tokens [$];
	token_rec_t   step_tokens [$];
	idle_mode_t   gen_mode  = IDLE_NONE;
	idle_mode_t   feed_mode = IDLE_NONE;
	int           bytes_taken    = 0;
	int           tokens_checked = 0;
	int           fail_count     = 0;
	int           idle_cycles    = 0;
	bit           seen_codes [64];

	// token predictor state
	lex_state_t  lx_state  = S_IDLE;
	logic [15:0] line_cnt  = 16'd1;
	logic [15:0] byte_pos  = '0;
	logic [15:0] tok_start = '0;
	logic [15:0] tok_len   = '0;
	logic [30:0] int_acc   = '0;
	logic [7:0]  char_val  = '0;
	string       ident_text;

	c_subset_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
			b == CH_USCORE;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	// keywords only match on the exact length; ident_text holds the first 8 bytes
	function automatic logic [5:0] word_code();
		for (int k = 0; k < 11; k++)
			if (tok_len == keyword_list[k].len() && ident_text == keyword_list[k])
				return TK_ID + 6'(k + 1);
		return TK_ID;
	endfunction

	task automatic emit_token(input logic [5:0] code, input logic [15:0] start,
			input logic [15:0] len, input logic [30:0] value);
		token_rec_t t;
		t.code  = code;
		t.line  = line_cnt;
		t.start = start;
		t.len   = len;
		t.value = value;
		t.last  = 1'b0;
		step_tokens.push_back(t);
	endtask

	task automatic extend_text();
		if (tok_len != 16'hFFFF)
			tok_len++;
	endtask

	task automatic open_token(input lex_state_t s, input logic [15:0] pos);
		lx_state  = s;
		tok_start = pos;
		tok_len   = 16'd1;
	endtask

	// byte seen from the start state
	task automatic start_token(input logic [7:0] b, input logic [15:0] pos);
		lx_state = S_IDLE;
		if (is_letter(b)) begin
			open_token(S_IDENT, pos);
			ident_text = $sformatf("%c", b);
		end else if (is_digit(b)) begin
			open_token(S_INT, pos);
			int_acc = 31'(b - CH_ZERO);
		end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
			open_token((b == CH_DQUOTE) ? S_STR : S_CHAR0, pos + 16'd1);
			tok_len = '0;
		end else begin
			case (b)
				CH_COMMA:  emit_token(TK_COMMA, pos, 1, 0);
				CH_SEMI:   emit_token(TK_SEMI, pos, 1, 0);
				CH_LPAREN: emit_token(TK_LPAREN, pos, 1, 0);
				CH_RPAREN: emit_token(TK_RPAREN, pos, 1, 0);
				CH_LBRACK: emit_token(TK_LBRACK, pos, 1, 0);
				CH_RBRACK: emit_token(TK_RBRACK, pos, 1, 0);
				CH_LBRACE: emit_token(TK_LBRACE, pos, 1, 0);
				CH_RBRACE: emit_token(TK_RBRACE, pos, 1, 0);
				CH_NUL:    emit_token(TK_END, pos, 0, 0);
				CH_PLUS:   emit_token(TK_ADD, pos, 1, 0);
				CH_MINUS:  emit_token(TK_SUB, pos, 1, 0);
				CH_STAR:   emit_token(TK_MUL, pos, 1, 0);
				CH_DOT:    emit_token(TK_DOT, pos, 1, 0);
				CH_AMP:    open_token(S_AMP, pos);
				CH_BAR:    open_token(S_BAR, pos);
				CH_BANG:   open_token(S_BANG, pos);
				CH_EQ:     open_token(S_EQ, pos);
				CH_LT:     open_token(S_LT, pos);
				CH_GT:     open_token(S_GT, pos);
				CH_SLASH:  open_token(S_SLASH, pos);
				CH_SPACE, CH_TAB, CH_CR: ;
				CH_LF: begin
					if (line_cnt != 16'hFFFF)
						line_cnt++;
				end
				default:   emit_token(TK_ERROR, pos, 1, 0);
			endcase
		end
	endtask

	// byte seen inside a token; taken low means it goes round again from idle
	task automatic continue_token(input logic [7:0] b, output logic taken);
		lex_state_t was;
		logic       dig;
		logic       bad;
		logic [5:0] code;
		longint     grown;
		was      = lx_state;
		dig      = is_digit(b);
		lx_state = S_IDLE;
		taken    = 1'b0;
		bad      = 1'b0;
		case (was)
			S_IDENT: begin
				if (is_letter(b) || dig) begin
					if (tok_len < 8)
						ident_text = $sformatf("%s%c", ident_text, b);
					extend_text();
					lx_state = S_IDENT;
					taken    = 1'b1;
				end else
					emit_token(word_code(), tok_start, tok_len, 0);
			end
			S_INT: begin
				if (dig) begin
					grown = longint'(int_acc) * 10 + longint'(b) - longint'(CH_ZERO);
					int_acc = (grown > longint'(VALUE_MAX)) ? VALUE_MAX : grown[30:0];
					extend_text();
					lx_state = S_INT;
					taken    = 1'b1;
				end else if (b == CH_DOT) begin
					extend_text();
					lx_state = S_DOT;
					taken    = 1'b1;
				end else if (b == CH_LOW_E || b == CH_UP_E) begin
					extend_text();
					lx_state = S_EXP;
					taken    = 1'b1;
				end else
					emit_token(TK_CT_INT, tok_start, tok_len, int_acc);
			end
			S_DOT: begin
				if (dig) begin
					extend_text();
					lx_state = S_FRAC;
					taken    = 1'b1;
				end else
					bad = 1'b1;
			end
			S_FRAC: begin
				if (dig || b == CH_LOW_E || b == CH_UP_E) begin
					extend_text();
					lx_state = dig ? S_FRAC : S_EXP;
					taken    = 1'b1;
				end else
					emit_token(TK_CT_REAL, tok_start, tok_len, 0);
			end
			S_EXP: begin
				if (b == CH_PLUS || b == CH_MINUS || dig) begin
					extend_text();
					lx_state = dig ? S_EDIG : S_ESIGN;
					taken    = 1'b1;
				end else
					bad = 1'b1;
			end
			S_ESIGN: begin
				if (dig) begin
					extend_text();
					lx_state = S_EDIG;
					taken    = 1'b1;
				end else
					bad = 1'b1;
			end
			S_EDIG: begin
				if (dig) begin
					extend_text();
					lx_state = S_EDIG;
					taken    = 1'b1;
				end else
					emit_token(TK_CT_REAL, tok_start, tok_len, 0);
			end
			S_CHAR0: begin
				if (b == CH_SQUOTE) begin
					// empty char constant swallows its closing quote
					emit_token(TK_ERROR, tok_start, 0, 0);
					taken = 1'b1;
				end else if (b == CH_NUL)
					bad = 1'b1;
				else begin
					char_val = b;
					tok_len  = 16'd1;
					lx_state = S_CHAR1;
					taken    = 1'b1;
				end
			end
			S_CHAR1: begin
				if (b == CH_SQUOTE) begin
					emit_token(TK_CT_CHAR, tok_start, 1, {23'd0, char_val});
					taken = 1'b1;
				end else
					bad = 1'b1;
			end
			S_STR: begin
				if (b == CH_DQUOTE) begin
					emit_token(TK_CT_STRING, tok_start, tok_len, 0);
					taken = 1'b1;
				end else if (b == CH_NUL)
					bad = 1'b1;
				else begin
					extend_text();
					lx_state = S_STR;
					taken    = 1'b1;
				end
			end
			S_AMP, S_BAR: begin
				if (was == S_AMP && b == CH_AMP) begin
					emit_token(TK_AND, tok_start, 2, 0);
					taken = 1'b1;
				end else if (was == S_BAR && b == CH_BAR) begin
					emit_token(TK_OR, tok_start, 2, 0);
					taken = 1'b1;
				end else
					bad = 1'b1;
			end
			S_BANG, S_EQ, S_LT, S_GT: begin
				if (b == CH_EQ) begin
					case (was)
						S_BANG:  code = TK_NOTEQ;
						S_EQ:    code = TK_EQUAL;
						S_LT:    code = TK_LESSEQ;
						default: code = TK_GREATEREQ;
					endcase
					emit_token(code, tok_start, 2, 0);
					taken = 1'b1;
				end else begin
					case (was)
						S_BANG:  code = TK_NOT;
						S_EQ:    code = TK_ASSIGN;
						S_LT:    code = TK_LESS;
						default: code = TK_GREATER;
					endcase
					emit_token(code, tok_start, 1, 0);
				end
			end
			S_SLASH: begin
				if (b == CH_SLASH) begin
					lx_state = S_COMMENT;
					taken    = 1'b1;
				end else
					emit_token(TK_DIV, tok_start, 1, 0);
			end
			S_COMMENT: begin
				// line ends and zero leave the comment and are lexed afresh
				if (!(b == CH_LF || b == CH_CR || b == CH_NUL)) begin
					lx_state = S_COMMENT;
					taken    = 1'b1;
				end
			end
			default: ;
		endcase
		if (bad)
			emit_token(TK_ERROR, tok_start, tok_len, 0);
	endtask

	// one accepted request: up to two tokens, the final one flagged last
	task automatic lex_byte(input logic [7:0] b);
		logic        taken;
		logic [15:0] pos;
		taken = 1'b0;
		pos   = byte_pos;
		step_tokens.delete();
		if (lx_state != S_IDLE)
			continue_token(b, taken);
		if (!taken)
			start_token(b, pos);
		byte_pos = pos + 16'd1;
		if (step_tokens.size() != 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic check_token();
		token_rec_t want;
		if (expected_tokens.size() == 0) begin
			fail_count++;
			$error("token code %0d arrived with none expected", m_tdata[5:0]);
			return;
		end
		want = expected_tokens.pop_front();
		seen_codes[m_tdata[5:0]] = 1'b1;
		check_field("token_code", want.code, m_tdata[5:0]);
		check_field("line_number", want.line, m_tdata[21:6]);
		check_field("start_position", want.start, m_tdata[37:22]);
		check_field("token_length", want.len, m_tdata[53:38]);
		check_field("token_value", want.value, m_tdata[84:54]);
		check_field("tdata padding", 0, m_tdata[87:85]);
		check_field("last_of_run", want.last, m_tlast);
		tokens_checked++;
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(52);
		if (r < 26)
			return 8'(CH_LOW_A + r);
		if (r < 52)
			return 8'(CH_UP_A + r - 26);
		return CH_USCORE;
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(CH_ZERO + $urandom_range(9));
	endfunction

	// any non-zero byte other than the two given
	function automatic logic [7:0] rand_text(input logic [7:0] no1, input logic [7:0] no2);
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == no1 || b == no2);
		return b;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		source_item_t it;
		it.b    = b;
		it.mode = gen_mode;
		source_bytes.push_back(it);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_broken();
		case ($urandom_range(6))
			0: begin
				add_byte(CH_AMP);
				add_byte(rand_letter());
			end
			1: begin
				add_byte(CH_BAR);
				add_byte(rand_digit());
			end
			2: begin
				add_byte(rand_digit());
				add_byte($urandom_range(1) ? CH_LOW_E : CH_UP_E);
				if ($urandom_range(1))
					add_byte(CH_MINUS);
				add_byte(rand_letter());
			end
			3: begin
				add_byte(rand_digit());
				add_byte(CH_DOT);
				add_byte(rand_letter());
			end
			4: begin
				add_byte(CH_SQUOTE);
				add_byte(rand_text(CH_SQUOTE, CH_SQUOTE));
				add_byte(rand_text(CH_SQUOTE, CH_DQUOTE));
			end
			5: begin
				add_byte(CH_SQUOTE);
				add_byte(CH_SQUOTE);
			end
			default: begin
				add_byte($urandom_range(1) ? CH_DQUOTE : CH_SQUOTE);
				repeat ($urandom_range(2))
					add_byte(rand_text(CH_DQUOTE, CH_SQUOTE));
				add_byte(CH_NUL);
			end
		endcase
	endtask

	// mostly well-formed tokens with random content, some noise and broken ones
	task automatic add_token();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			add_byte(rand_letter());
			repeat ($urandom_range(7))
				add_byte($urandom_range(3) == 0 ? rand_digit() : rand_letter());
		end else if (roll < 25)
			add_text(keyword_list[$urandom_range(10)]);
		else if (roll < 37) begin
			// long ones push the value into saturation
			repeat ($urandom_range(9) == 0 ? $urandom_range(10, 12) : $urandom_range(1, 4))
				add_byte(rand_digit());
		end else if (roll < 45) begin
			repeat ($urandom_range(1, 3))
				add_byte(rand_digit());
			if ($urandom_range(2) != 0) begin
				add_byte(CH_DOT);
				repeat ($urandom_range(1, 3))
					add_byte(rand_digit());
			end
			if ($urandom_range(1)) begin
				add_byte($urandom_range(1) ? CH_LOW_E : CH_UP_E);
				case ($urandom_range(2))
					0: add_byte(CH_PLUS);
					1: add_byte(CH_MINUS);
					default: ;
				endcase
				repeat ($urandom_range(1, 2))
					add_byte(rand_digit());
			end
		end else if (roll < 52) begin
			add_byte(CH_SQUOTE);
			add_byte(rand_text(CH_SQUOTE, CH_SQUOTE));
			add_byte(CH_SQUOTE);
		end else if (roll < 59) begin
			add_byte(CH_DQUOTE);
			repeat ($urandom_range(10))
				add_byte(rand_text(CH_DQUOTE, CH_DQUOTE));
			add_byte(CH_DQUOTE);
		end else if (roll < 79)
			add_text(punct_list[$urandom_range(22)]);
		else if (roll < 84) begin
			add_byte(CH_SLASH);
			add_byte(CH_SLASH);
			repeat ($urandom_range(8))
				add_byte(rand_text(CH_LF, CH_CR));
			add_byte($urandom_range(1) ? CH_LF : CH_CR);
		end else if (roll < 92)
			add_broken();
		else if (roll < 96)
			add_byte(8'($urandom_range(255)));
		else if (roll < 98)
			add_byte(CH_NUL);
		else
			repeat ($urandom_range(1, 3))
				add_byte(CH_LF);
	endtask

	// ---------------------------------------------------------------- handshakes

	function automatic logic sender_rests(input idle_mode_t mode);
		case (mode)
			IDLE_SEND: return $urandom_range(99) < 88;
			IDLE_BOTH: return $urandom_range(99) < 36;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stalls(input idle_mode_t mode);
		case (mode)
			IDLE_RECV: return $urandom_range(99) < 88;
			IDLE_BOTH: return $urandom_range(99) < 36;
			default:   return 1'b0;
		endcase
	endfunction

	// request driver: a new byte goes out once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (source_bytes.size() != 0 && !sender_rests(source_bytes[0].mode)) begin
				s_tvalid  <= 1'b1;
				s_tdata   <= source_bytes[0].b;
				feed_mode <= source_bytes[0].mode;
				void'(source_bytes.pop_front());
			end else
				s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !receiver_stalls(feed_mode);
	end

	// monitor: predict on each accepted request, check each accepted token
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				lex_byte(s_tdata);
				bytes_taken++;
			end
			if (m_tvalid && m_tready)
				check_token();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("timeout: no handshake for %0d cycles, %0d tokens outstanding",
			STALL_LIMIT, expected_tokens.size());
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int kinds;
		int total_bytes;
		kinds = 0;
		gen_mode = IDLE_NONE;
		foreach (OPENING[i])
			add_byte(OPENING[i]);
		while (source_bytes.size() < SOURCE_ITEMS - TAIL_ROOM) begin
			gen_mode = idle_mode_t'((source_bytes.size() / 120) % 4);
			add_token();
			if ($urandom_range(99) < 55)
				add_byte(BLANKS[$urandom_range(3)]);
		end
		gen_mode = IDLE_BOTH;
		repeat (60)
			add_token();
		add_byte(CH_NUL);
		total_bytes = source_bytes.size();

		@(posedge arst_n);
		while (bytes_taken != total_bytes)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		foreach (seen_codes[c])
			if (seen_codes[c])
				kinds++;
		$display("Lexed %0d source bytes into %0d checked tokens, %0d token codes seen.",
			bytes_taken, tokens_checked, kinds);
		$display("Run took in stalls on both sides, broken tokens and saturated values.");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
